[rtl/prcp_pkg.sv]
// Package for the pixel replicate and clip placer.
// Holds the register indexes, reset values, the register bank type and queue sizing.
// No dependencies.
package prcp_pkg;

  localparam int REG_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int MAG_W     = 4;
  localparam int JM_W      = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_JUSTIFY_MODE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGNIFY      = 3'd7;

  localparam int JUST_RIGHT  = 0;
  localparam int JUST_BOTTOM = 1;

  localparam logic [REG_W-1:0] RST_SCREEN_COLS = 13'd1024;
  localparam logic [REG_W-1:0] RST_SCREEN_ROWS = 13'd768;
  localparam logic [REG_W-1:0] RST_IMAGE_COLS  = 13'd640;
  localparam logic [REG_W-1:0] RST_IMAGE_ROWS  = 13'd480;
  localparam logic [MAG_W-1:0] RST_MAGNIFY     = 4'd1;

  typedef struct packed {
    logic        [REG_W-1:0] screen_cols;
    logic        [REG_W-1:0] screen_rows;
    logic        [REG_W-1:0] image_cols;
    logic        [REG_W-1:0] image_rows;
    logic signed [REG_W-1:0] offset_x;
    logic signed [REG_W-1:0] offset_y;
    logic        [JM_W-1:0]  justify_mode;
    logic        [MAG_W-1:0] magnify;
  } cfg_t;

endpackage

[rtl/prcp_front.sv]
// Front end of the placer: source counters, placement arithmetic and clipping.
// Three register stages; kept pixels go out as write spans to the queue.
// Depends on prcp_pkg.
module prcp_front #(
  parameter int PIXEL_BITS  = 32,
  parameter int COORD_BITS  = 12,
  parameter int MAX_MAGNIFY = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  prcp_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  input  logic                  in_frame_start,
  input  logic                  q_ready,
  output logic                  q_push,
  output logic [PIXEL_BITS-1:0] q_pixel,
  output logic [COORD_BITS-1:0] q_row_first,
  output logic [COORD_BITS-1:0] q_row_last,
  output logic [COORD_BITS-1:0] q_col_first,
  output logic [COORD_BITS-1:0] q_col_last
);

  localparam int SZ_W   = COORD_BITS + 1;
  localparam int EXT_W  = (SZ_W > prcp_pkg::REG_W) ? SZ_W : prcp_pkg::REG_W;
  localparam int PROD_W = SZ_W + prcp_pkg::MAG_W;
  localparam int SW     = ((COORD_BITS > 12) ? COORD_BITS : 12) + 6;
  localparam logic [EXT_W-1:0] LIMIT = EXT_W'(1) << COORD_BITS;

  // Effective sizes and factor after clamping.
  logic [EXT_W-1:0]          ic_ext, ir_ext, sc_ext, sr_ext;
  logic [SZ_W-1:0]           w_eff, h_eff, sx_eff, sy_eff;
  logic [prcp_pkg::MAG_W-1:0] m_eff;

  always_comb begin
    ic_ext = EXT_W'(cfg.image_cols);
    ir_ext = EXT_W'(cfg.image_rows);
    sc_ext = EXT_W'(cfg.screen_cols);
    sr_ext = EXT_W'(cfg.screen_rows);
    if (ic_ext == '0) w_eff = SZ_W'(1);
    else if (ic_ext > LIMIT) w_eff = SZ_W'(LIMIT);
    else w_eff = SZ_W'(ic_ext);
    if (ir_ext == '0) h_eff = SZ_W'(1);
    else if (ir_ext > LIMIT) h_eff = SZ_W'(LIMIT);
    else h_eff = SZ_W'(ir_ext);
    sx_eff = (sc_ext > LIMIT) ? SZ_W'(LIMIT) : SZ_W'(sc_ext);
    sy_eff = (sr_ext > LIMIT) ? SZ_W'(LIMIT) : SZ_W'(sr_ext);
    if (cfg.magnify == '0) m_eff = prcp_pkg::MAG_W'(1);
    else if (cfg.magnify > prcp_pkg::MAG_W'(MAX_MAGNIFY)) m_eff = prcp_pkg::MAG_W'(MAX_MAGNIFY);
    else m_eff = cfg.magnify;
  end

  // Stage registers.
  logic                       s1_v_r, s2_v_r, s3_v_r, s3_keep_r;
  logic                       s1_v_nxt, s2_v_nxt, s3_v_nxt;
  logic                       s1_free, s2_free, s3_free, in_acc;
  logic [PIXEL_BITS-1:0]      s1_pix_r, s2_pix_r, s3_pix_r;
  logic [prcp_pkg::MAG_W-1:0] s1_m_r, s2_m_r;
  logic [PROD_W-1:0]          s1_rm_r, s1_cm_r, s1_wm_r, s1_hm_r;
  logic signed [SW-1:0]       s2_row0_r, s2_col0_r;
  logic [COORD_BITS-1:0]      s3_rs_r, s3_re_r, s3_cs_r, s3_ce_r;

  assign s3_free  = !s3_v_r || !s3_keep_r || q_ready;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;
  assign in_acc   = in_valid && in_ready;

  // Source counters.
  logic [COORD_BITS-1:0] col_r, row_r, col_nxt, row_nxt, cur_col, cur_row;
  logic [SZ_W-1:0]       col_inc, row_inc;

  always_comb begin
    cur_col = in_frame_start ? '0 : col_r;
    cur_row = in_frame_start ? '0 : row_r;
    col_inc = {1'b0, cur_col} + SZ_W'(1);
    row_inc = {1'b0, cur_row} + SZ_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : row_inc[COORD_BITS-1:0];
      end else begin
        col_nxt = col_inc[COORD_BITS-1:0];
        row_nxt = cur_row;
      end
    end
  end

  // Stage 2 inputs: origin of the pixel's block.
  logic signed [SW-1:0] cb_adj, rb_adj, col0, row0;

  always_comb begin
    cb_adj = '0;
    rb_adj = '0;
    if (cfg.justify_mode[prcp_pkg::JUST_RIGHT]) begin
      cb_adj = signed'(SW'(sx_eff)) - signed'(SW'(s1_wm_r));
    end
    if (cfg.justify_mode[prcp_pkg::JUST_BOTTOM]) begin
      rb_adj = signed'(SW'(sy_eff)) - signed'(SW'(s1_hm_r));
    end
    col0 = SW'(cfg.offset_x) + cb_adj + signed'(SW'(s1_cm_r));
    row0 = SW'(cfg.offset_y) + rb_adj + signed'(SW'(s1_rm_r));
  end

  // Stage 3 inputs: clip the block against the screen.
  logic signed [SW-1:0] rlast, clast, rs, re, cs, ce;
  logic                 keep;

  always_comb begin
    rlast = s2_row0_r + signed'(SW'(s2_m_r)) - SW'(1);
    clast = s2_col0_r + signed'(SW'(s2_m_r)) - SW'(1);
    rs    = (s2_row0_r < 0) ? '0 : s2_row0_r;
    cs    = (s2_col0_r < 0) ? '0 : s2_col0_r;
    re    = (rlast >= signed'(SW'(sy_eff))) ? signed'(SW'(sy_eff)) - SW'(1) : rlast;
    ce    = (clast >= signed'(SW'(sx_eff))) ? signed'(SW'(sx_eff)) - SW'(1) : clast;
    keep  = (rs <= re) && (cs <= ce);
  end

  always_comb begin
    s1_v_nxt = s1_free ? in_acc : s1_v_r;
    s2_v_nxt = s2_free ? s1_v_r : s2_v_r;
    s3_v_nxt = s3_free ? s2_v_r : s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s3_keep_r <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      if (s3_free) begin
        s3_keep_r <= keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r <= in_pixel;
      s1_m_r   <= m_eff;
      s1_rm_r  <= PROD_W'({1'b0, cur_row}) * PROD_W'(m_eff);
      s1_cm_r  <= PROD_W'({1'b0, cur_col}) * PROD_W'(m_eff);
      s1_wm_r  <= PROD_W'(w_eff) * PROD_W'(m_eff);
      s1_hm_r  <= PROD_W'(h_eff) * PROD_W'(m_eff);
    end
    if (s2_free && s1_v_r) begin
      s2_pix_r  <= s1_pix_r;
      s2_m_r    <= s1_m_r;
      s2_row0_r <= row0;
      s2_col0_r <= col0;
    end
    if (s3_free && s2_v_r) begin
      s3_pix_r <= s2_pix_r;
      s3_rs_r  <= rs[COORD_BITS-1:0];
      s3_re_r  <= re[COORD_BITS-1:0];
      s3_cs_r  <= cs[COORD_BITS-1:0];
      s3_ce_r  <= ce[COORD_BITS-1:0];
    end
  end

  assign q_push      = s3_v_r && s3_keep_r && q_ready;
  assign q_pixel     = s3_pix_r;
  assign q_row_first = s3_rs_r;
  assign q_row_last  = s3_re_r;
  assign q_col_first = s3_cs_r;
  assign q_col_last  = s3_ce_r;

endmodule

[rtl/prcp_queue.sv]
// Short FIFO of write spans between the front end and the write sequencer.
// Depth comes from prcp_pkg; the entry width is a parameter.
// Depends on prcp_pkg.
module prcp_queue #(
  parameter int DATA_W = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              ready,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] rdata
);

  localparam int CNT_W = prcp_pkg::QPTR_W + 1;

  logic [DATA_W-1:0]           slot_r [prcp_pkg::QUEUE_DEPTH];
  logic [prcp_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        do_pop;

  assign ready  = count_r != CNT_W'(prcp_pkg::QUEUE_DEPTH);
  assign valid  = count_r != '0;
  assign do_pop = pop && valid;
  assign rdata  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) count_nxt = count_r + CNT_W'(1);
    else if (!push && do_pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + prcp_pkg::QPTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + prcp_pkg::QPTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/prcp_back.sv]
// Write sequencer: walks each queued span row by row and column by column.
// Drives the registered output channel, one framebuffer write per cycle unless out_ready stalls it.
// Depends on no package items.
module prcp_back #(
  parameter int PIXEL_BITS = 32,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic [PIXEL_BITS-1:0] q_pixel,
  input  logic [COORD_BITS-1:0] q_row_first,
  input  logic [COORD_BITS-1:0] q_row_last,
  input  logic [COORD_BITS-1:0] q_col_first,
  input  logic [COORD_BITS-1:0] q_col_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_screen_row,
  output logic [COORD_BITS-1:0] out_screen_col,
  output logic [PIXEL_BITS-1:0] out_pixel_out,
  output logic                  out_last_write
);

  logic                  work_v_r, work_v_nxt, out_v_r, out_v_nxt;
  logic [PIXEL_BITS-1:0] pix_r;
  logic [COORD_BITS-1:0] row_r, col_r, re_r, cs_r, ce_r;
  logic                  emit, row_end, col_end, done, load;

  assign emit    = work_v_r && (!out_v_r || out_ready);
  assign col_end = col_r == ce_r;
  assign row_end = row_r == re_r;
  assign done    = emit && col_end && row_end;
  assign load    = q_valid && (!work_v_r || done);
  assign q_pop   = load;

  always_comb begin
    work_v_nxt = work_v_r;
    if (load) work_v_nxt = 1'b1;
    else if (done) work_v_nxt = 1'b0;
    out_v_nxt = out_v_r;
    if (emit) out_v_nxt = 1'b1;
    else if (out_ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      work_v_r <= work_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_r <= q_pixel;
      row_r <= q_row_first;
      re_r  <= q_row_last;
      col_r <= q_col_first;
      cs_r  <= q_col_first;
      ce_r  <= q_col_last;
    end else if (emit) begin
      if (col_end) begin
        col_r <= cs_r;
        row_r <= row_r + COORD_BITS'(1);
      end else begin
        col_r <= col_r + COORD_BITS'(1);
      end
    end
    if (emit) begin
      out_screen_row <= row_r;
      out_screen_col <= col_r;
      out_pixel_out  <= pix_r;
      out_last_write <= col_end && row_end;
    end
  end

  assign out_valid = out_v_r;

endmodule

[rtl/pixel_replicate_clip_placer.sv]
// Throughput: one framebuffer write per cycle while out_ready stays high, set by the
// write sequencer; a pixel gives up to magnify*magnify writes when none is clipped.
// Reset (rst_n low, synchronous) loads the register defaults, clears the source
// counters, empties the pipeline and queue and drops out_valid.
//
// Top level of the pixel replicate and clip placer. Depends on prcp_pkg, prcp_front,
// prcp_queue and prcp_back.
module pixel_replicate_clip_placer #(
  parameter int PIXEL_BITS  = 32,
  parameter int COORD_BITS  = 12,
  parameter int MAX_MAGNIFY = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [prcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prcp_pkg::REG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [PIXEL_BITS-1:0]          in_pixel,
  input  logic                           in_frame_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [COORD_BITS-1:0]          out_screen_row,
  output logic [COORD_BITS-1:0]          out_screen_col,
  output logic [PIXEL_BITS-1:0]          out_pixel_out,
  output logic                           out_last_write
);

  // A queue entry is one pixel plus the clipped row and column span it covers.
  localparam int ENTRY_W = PIXEL_BITS + 4 * COORD_BITS;

  // Register bank. The user must write only while the block is idle (not enforced
  // by the block), so the front end can read these values directly at every stage.
  prcp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_cols  <= prcp_pkg::RST_SCREEN_COLS;
      cfg_r.screen_rows  <= prcp_pkg::RST_SCREEN_ROWS;
      cfg_r.image_cols   <= prcp_pkg::RST_IMAGE_COLS;
      cfg_r.image_rows   <= prcp_pkg::RST_IMAGE_ROWS;
      cfg_r.offset_x     <= '0;
      cfg_r.offset_y     <= '0;
      cfg_r.justify_mode <= '0;
      cfg_r.magnify      <= prcp_pkg::RST_MAGNIFY;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        prcp_pkg::CFG_SCREEN_COLS:  cfg_r.screen_cols  <= cfg_wdata;
        prcp_pkg::CFG_SCREEN_ROWS:  cfg_r.screen_rows  <= cfg_wdata;
        prcp_pkg::CFG_IMAGE_COLS:   cfg_r.image_cols   <= cfg_wdata;
        prcp_pkg::CFG_IMAGE_ROWS:   cfg_r.image_rows   <= cfg_wdata;
        prcp_pkg::CFG_OFFSET_X:     cfg_r.offset_x     <= signed'(cfg_wdata);
        prcp_pkg::CFG_OFFSET_Y:     cfg_r.offset_y     <= signed'(cfg_wdata);
        prcp_pkg::CFG_JUSTIFY_MODE: cfg_r.justify_mode <= cfg_wdata[prcp_pkg::JM_W-1:0];
        prcp_pkg::CFG_MAGNIFY:      cfg_r.magnify      <= cfg_wdata[prcp_pkg::MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // The front end accepts a pixel every cycle unless its last stage is held by
  // a full queue. Pixels that are clipped away entirely never enter the queue,
  // but the source counters still advance for them.
  logic                  q_push, q_ready, q_valid, q_pop;
  logic [PIXEL_BITS-1:0] f_pixel, b_pixel;
  logic [COORD_BITS-1:0] f_rs, f_re, f_cs, f_ce, b_rs, b_re, b_cs, b_ce;
  logic [ENTRY_W-1:0]    q_wdata, q_rdata;

  prcp_front #(
    .PIXEL_BITS  (PIXEL_BITS),
    .COORD_BITS  (COORD_BITS),
    .MAX_MAGNIFY (MAX_MAGNIFY)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_pixel        (f_pixel),
    .q_row_first    (f_rs),
    .q_row_last     (f_re),
    .q_col_first    (f_cs),
    .q_col_last     (f_ce)
  );

  assign q_wdata = {f_pixel, f_rs, f_re, f_cs, f_ce};

  prcp_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .ready (q_ready),
    .wdata (q_wdata),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign {b_pixel, b_rs, b_re, b_cs, b_ce} = q_rdata;

  // The sequencer loads the next span in the same cycle as the last write of the
  // current one, so magnify 1 runs at one pixel per cycle while out_ready is high.
  prcp_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_pixel        (b_pixel),
    .q_row_first    (b_rs),
    .q_row_last     (b_re),
    .q_col_first    (b_cs),
    .q_col_last     (b_ce),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_screen_row (out_screen_row),
    .out_screen_col (out_screen_col),
    .out_pixel_out  (out_pixel_out),
    .out_last_write (out_last_write)
  );

  // Every emitted write must land inside the screen.
  localparam int CHK_W = ((COORD_BITS > prcp_pkg::REG_W) ? COORD_BITS : prcp_pkg::REG_W) + 1;

  a_col_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CHK_W'(cfg_r.screen_cols) > CHK_W'(out_screen_col)))
    else $error("write column outside the screen");

  a_row_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CHK_W'(cfg_r.screen_rows) > CHK_W'(out_screen_row)))
    else $error("write row outside the screen");

  // A span is only popped when the queue holds one.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

[dv/prcp_write_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the pixel replicate and clip placer: mirrors the register writes, predicts
// the framebuffer writes of every accepted pixel and checks them on the result channel.
// Depends on prcp_pkg.
module prcp_write_checker #(
  parameter int PIXEL_BITS  = 32,
  parameter int COORD_BITS  = 12,
  parameter int MAX_MAGNIFY = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [prcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prcp_pkg::REG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [PIXEL_BITS-1:0]          in_pixel,
  input  logic                           in_frame_start,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [COORD_BITS-1:0]          out_screen_row,
  input  logic [COORD_BITS-1:0]          out_screen_col,
  input  logic [PIXEL_BITS-1:0]          out_pixel_out,
  input  logic                           out_last_write,
  output int                             error_count,
  output int                             pending_writes
);

  localparam int COORD_LIMIT = 1 << COORD_BITS;

  typedef struct packed {
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  last;
  } fb_write_t;

  prcp_pkg::cfg_t        regs;
  logic [COORD_BITS-1:0] src_col;
  logic [COORD_BITS-1:0] src_row;
  fb_write_t             expected_writes[$];

  // Sizes above the coordinate range saturate; image sizes of zero count as one.
  function automatic int clamp_size(input logic [prcp_pkg::REG_W-1:0] v, input bit zero_as_one);
    if (v == '0 && zero_as_one) return 1;
    if (int'(v) > COORD_LIMIT) return COORD_LIMIT;
    return int'(v);
  endfunction

  task automatic place_pixel(input logic [PIXEL_BITS-1:0] pix, input logic frame_start);
    int        m, w, h, sx, sy, cb, rb, row, col;
    bit        have_prev;
    fb_write_t prev;
    have_prev = 1'b0;
    prev      = '0;
    if (regs.magnify == '0) m = 1;
    else if (int'(regs.magnify) > MAX_MAGNIFY) m = MAX_MAGNIFY;
    else m = int'(regs.magnify);
    w  = clamp_size(regs.image_cols, 1'b1);
    h  = clamp_size(regs.image_rows, 1'b1);
    sx = clamp_size(regs.screen_cols, 1'b0);
    sy = clamp_size(regs.screen_rows, 1'b0);
    if (frame_start) begin
      src_col = '0;
      src_row = '0;
    end
    cb = regs.offset_x;
    rb = regs.offset_y;
    if (regs.justify_mode[prcp_pkg::JUST_RIGHT]) cb = cb + sx - w * m;
    if (regs.justify_mode[prcp_pkg::JUST_BOTTOM]) rb = rb + sy - h * m;
    for (int i = 0; i < m; i++) begin
      row = rb + int'(src_row) * m + i;
      if (row >= 0 && row < sy) begin
        for (int j = 0; j < m; j++) begin
          col = cb + int'(src_col) * m + j;
          if (col >= 0 && col < sx) begin
            // Hold each write back by one so the final one can carry the last flag.
            if (have_prev) expected_writes.push_back(prev);
            prev.row   = row[COORD_BITS-1:0];
            prev.col   = col[COORD_BITS-1:0];
            prev.pixel = pix;
            prev.last  = 1'b0;
            have_prev  = 1'b1;
          end
        end
      end
    end
    if (have_prev) begin
      prev.last = 1'b1;
      expected_writes.push_back(prev);
    end
    if (int'(src_col) + 1 >= w) begin
      src_col = '0;
      if (int'(src_row) + 1 >= h) src_row = '0;
      else src_row = src_row + 1'b1;
    end else begin
      src_col = src_col + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [PIXEL_BITS-1:0] exp_val,
                             input logic [PIXEL_BITS-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  initial begin
    error_count    = 0;
    pending_writes = 0;
  end

  always @(posedge clk) begin
    fb_write_t exp_wr;
    if (!rst_n) begin
      regs.screen_cols  = prcp_pkg::RST_SCREEN_COLS;
      regs.screen_rows  = prcp_pkg::RST_SCREEN_ROWS;
      regs.image_cols   = prcp_pkg::RST_IMAGE_COLS;
      regs.image_rows   = prcp_pkg::RST_IMAGE_ROWS;
      regs.offset_x     = '0;
      regs.offset_y     = '0;
      regs.justify_mode = '0;
      regs.magnify      = prcp_pkg::RST_MAGNIFY;
      src_col = '0;
      src_row = '0;
      expected_writes.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          prcp_pkg::CFG_SCREEN_COLS:  regs.screen_cols  = cfg_wdata;
          prcp_pkg::CFG_SCREEN_ROWS:  regs.screen_rows  = cfg_wdata;
          prcp_pkg::CFG_IMAGE_COLS:   regs.image_cols   = cfg_wdata;
          prcp_pkg::CFG_IMAGE_ROWS:   regs.image_rows   = cfg_wdata;
          prcp_pkg::CFG_OFFSET_X:     regs.offset_x     = cfg_wdata;
          prcp_pkg::CFG_OFFSET_Y:     regs.offset_y     = cfg_wdata;
          prcp_pkg::CFG_JUSTIFY_MODE: regs.justify_mode = cfg_wdata[prcp_pkg::JM_W-1:0];
          prcp_pkg::CFG_MAGNIFY:      regs.magnify      = cfg_wdata[prcp_pkg::MAG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) place_pixel(in_pixel, in_frame_start);
      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          $error("write to row %0d col %0d with nothing expected",
                 out_screen_row, out_screen_col);
          error_count++;
        end else begin
          exp_wr = expected_writes.pop_front();
          check_field("screen_row", exp_wr.row, out_screen_row);
          check_field("screen_col", exp_wr.col, out_screen_col);
          check_field("pixel_out", exp_wr.pixel, out_pixel_out);
          check_field("last_write", exp_wr.last, out_last_write);
        end
      end
    end
    pending_writes = expected_writes.size();
  end

endmodule

[dv/pixel_replicate_clip_placer_tb.sv]
`timescale 1ns / 1ps
// Top of the testbench for the pixel replicate and clip placer: clock, reset, register
// programming, pixel stimulus and the verdict. Depends on prcp_pkg, the block and
// prcp_write_checker.
module pixel_replicate_clip_placer_tb;

  localparam int PIXEL_BITS     = 32;
  localparam int COORD_BITS     = 12;
  localparam int MAX_MAGNIFY    = 8;
  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 9;
  localparam int IDLE_PCT       = 26;
  // The block has a pipelined front end and a small queue; pixels whose writes are all
  // clipped can still be in flight after the last expected write, so allow a margin.
  localparam int SETTLE_CYCLES  = 32;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_ITEMS    = 9;
  localparam int TIMEOUT_NS     = 4_000_000;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [prcp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [prcp_pkg::REG_W-1:0]      cfg_wdata;
  logic                            in_valid;
  logic                            in_ready;
  logic [PIXEL_BITS-1:0]           in_pixel;
  logic                            in_frame_start;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [COORD_BITS-1:0]           out_screen_row;
  logic [COORD_BITS-1:0]           out_screen_col;
  logic [PIXEL_BITS-1:0]           out_pixel_out;
  logic                            out_last_write;

  int error_count;
  int pending_writes;
  int tx_idle_pct = IDLE_PCT;
  int rx_idle_pct = IDLE_PCT;
  bit rx_hold_req = 1'b0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  pixel_replicate_clip_placer #(
    .PIXEL_BITS (PIXEL_BITS),
    .COORD_BITS (COORD_BITS),
    .MAX_MAGNIFY(MAX_MAGNIFY)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel      (in_pixel),
    .in_frame_start(in_frame_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_screen_row(out_screen_row),
    .out_screen_col(out_screen_col),
    .out_pixel_out (out_pixel_out),
    .out_last_write(out_last_write)
  );

  // The checker sits beside the block, watching every channel, and reports back how many
  // failures it has seen and how many framebuffer writes are still outstanding.
  prcp_write_checker #(
    .PIXEL_BITS (PIXEL_BITS),
    .COORD_BITS (COORD_BITS),
    .MAX_MAGNIFY(MAX_MAGNIFY)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel      (in_pixel),
    .in_frame_start(in_frame_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_screen_row(out_screen_row),
    .out_screen_col(out_screen_col),
    .out_pixel_out (out_pixel_out),
    .out_last_write(out_last_write),
    .error_count   (error_count),
    .pending_writes(pending_writes)
  );

  // Receiver. It changes out_ready on the falling edge only. When a hold-off is requested
  // it keeps ready low for a long stretch, counted here, so the block backs up and
  // eventually stalls its input while the sender keeps offering pixels.
  always begin
    @(negedge clk);
    if (rx_hold_req) begin
      out_ready   = 1'b0;
      rx_hold_req = 1'b0;
      repeat (RX_HOLD_CYCLES) @(negedge clk);
    end
    out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Safety net: a hung handshake ends the run here.
  initial begin
    #TIMEOUT_NS;
    $display("FAIL");
    $finish;
  end

  function automatic prcp_pkg::cfg_t make_cfg(input int sc, input int sr, input int ic,
                                              input int ir, input int ox, input int oy,
                                              input int jm, input int mg);
    prcp_pkg::cfg_t c;
    c.screen_cols  = sc[prcp_pkg::REG_W-1:0];
    c.screen_rows  = sr[prcp_pkg::REG_W-1:0];
    c.image_cols   = ic[prcp_pkg::REG_W-1:0];
    c.image_rows   = ir[prcp_pkg::REG_W-1:0];
    c.offset_x     = ox[prcp_pkg::REG_W-1:0];
    c.offset_y     = oy[prcp_pkg::REG_W-1:0];
    c.justify_mode = jm[prcp_pkg::JM_W-1:0];
    c.magnify      = mg[prcp_pkg::MAG_W-1:0];
    return c;
  endfunction

  // Mostly small frames on small screens so that most pixels land on screen, with an
  // occasional register at its full range to reach the clamping and clipping corners.
  function automatic int rand_screen();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 8191);
      1:       return 4096;
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  function automatic int rand_image();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 8191);
    return $urandom_range(1, 6);
  endfunction

  function automatic int rand_offset();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 8191);
    return $urandom_range(0, 24) - 12;
  endfunction

  function automatic prcp_pkg::cfg_t random_cfg();
    int mg;
    if ($urandom_range(0, 9) == 0) mg = $urandom_range(0, 15);
    else mg = $urandom_range(1, 4);
    return make_cfg(rand_screen(), rand_screen(), rand_image(), rand_image(),
                    rand_offset(), rand_offset(), $urandom_range(0, 3), mg);
  endfunction

  // One register write per falling edge. The enable is left high between back-to-back
  // writes and lowered by the caller once the last one is done.
  task automatic write_reg(input logic [prcp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [prcp_pkg::REG_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
  endtask

  task automatic apply_config(input prcp_pkg::cfg_t c);
    write_reg(prcp_pkg::CFG_SCREEN_COLS, c.screen_cols);
    write_reg(prcp_pkg::CFG_SCREEN_ROWS, c.screen_rows);
    write_reg(prcp_pkg::CFG_IMAGE_COLS, c.image_cols);
    write_reg(prcp_pkg::CFG_IMAGE_ROWS, c.image_rows);
    write_reg(prcp_pkg::CFG_OFFSET_X, c.offset_x);
    write_reg(prcp_pkg::CFG_OFFSET_Y, c.offset_y);
    write_reg(prcp_pkg::CFG_JUSTIFY_MODE,
              {{(prcp_pkg::REG_W-prcp_pkg::JM_W){1'b0}}, c.justify_mode});
    write_reg(prcp_pkg::CFG_MAGNIFY,
              {{(prcp_pkg::REG_W-prcp_pkg::MAG_W){1'b0}}, c.magnify});
    cfg_wr_en = 1'b0;
  endtask

  // Offers one pixel transaction, sometimes after random idle cycles, and returns on the
  // falling edge after it was accepted. Valid stays high so that a following call
  // presents the next pixel back to back without a bubble.
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input logic fs);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_pixel       = pix;
    in_frame_start = fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted write has come out, then lets the
  // pipeline settle so that the block is idle before any register changes.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_writes != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    prcp_pkg::cfg_t c;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_pixel       = '0;
    in_frame_start = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Register defaults straight out of reset, with the extreme pixel values.
    send_pixel('0, 1'b1);
    send_pixel('1, 1'b0);
    send_pixel(32'hA5A5_5A5A, 1'b0);
    wait_idle();

    // A 3x2 image doubled on an 8x6 screen: the seventh pixel wraps back to the origin.
    apply_config(make_cfg(8, 6, 3, 2, 0, 0, 0, 2));
    send_pixel(32'h0000_0001, 1'b1);
    for (int k = 0; k < 6; k++) send_pixel($urandom, 1'b0);
    wait_idle();

    // Aligned to the right and bottom edges with a negative offset, so blocks are cut on
    // the left and top.
    apply_config(make_cfg(5, 5, 2, 2, -1, -1, 3, 3));
    send_pixel(32'h8000_0000, 1'b1);
    for (int k = 0; k < 3; k++) send_pixel($urandom, 1'b0);
    wait_idle();

    // Zero image size and zero magnify act as one; an oversized screen saturates, and
    // the largest offsets put the single pixel on the last row and column.
    apply_config(make_cfg(8191, 8191, 0, 0, 4095, 4095, 0, 0));
    send_pixel($urandom, 1'b1);
    send_pixel($urandom, 1'b0);
    wait_idle();

    // A screen of zero width drops every write; the counters still move.
    apply_config(make_cfg(0, 4096, 1, 1, -4096, -4096, 0, 15));
    send_pixel($urandom, 1'b1);
    send_pixel($urandom, 1'b0);
    wait_idle();

    // Magnify above the maximum saturates to eight: every write of the block lands.
    apply_config(make_cfg(4096, 8, 8191, 8191, 0, 0, 0, 9));
    send_pixel($urandom, 1'b1);
    send_pixel($urandom, 1'b0);
    wait_idle();

    // The image width shrinks mid-frame: a column counter already past the new width
    // still places its pixel there and wraps on the next advance.
    apply_config(make_cfg(16, 16, 4, 4, 0, 0, 0, 1));
    send_pixel($urandom, 1'b1);
    send_pixel($urandom, 1'b0);
    send_pixel($urandom, 1'b0);
    wait_idle();
    apply_config(make_cfg(16, 16, 2, 4, 0, 0, 0, 1));
    send_pixel($urandom, 1'b0);
    send_pixel($urandom, 1'b0);
    wait_idle();

    // Random phases: a fresh register set each time, then mostly well-formed frames
    // with random pixels and the odd frame restart in the middle.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      c = random_cfg();
      if (p == 2) begin
        // A stretch where neither side ever idles.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
      end
      if (p == 5) begin
        // Sixteen visible writes per pixel while the receiver holds off, so the queue
        // fills up and the input side has to stall.
        c = make_cfg(64, 64, 4, 4, 0, 0, 0, 4);
        rx_hold_req = 1'b1;
      end
      apply_config(c);
      send_pixel($urandom, ($urandom_range(0, 4) != 0));
      for (int k = 1; k < PHASE_ITEMS; k++)
        send_pixel($urandom, ($urandom_range(0, 19) == 0));
      wait_idle();
    end

    if (error_count == 0 && pending_writes == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/prcp_pkg.sv
rtl/prcp_front.sv
rtl/prcp_queue.sv
rtl/prcp_back.sv
rtl/pixel_replicate_clip_placer.sv
dv/prcp_write_checker.sv
dv/pixel_replicate_clip_placer_tb.sv
